FILE: hdl/kth_linear_extension_finder_core_defines.svh
// Assertion helpers used by the counting module, which checks its own sequencing.
`ifndef KTH_LINEAR_EXTENSION_FINDER_CORE_DEFINES_SVH
`define KTH_LINEAR_EXTENSION_FINDER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KLEF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KLEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/klef_pkg.sv
package klef_pkg;

    localparam int MAX_ITEMS_DEF = 16;
    localparam int COUNT_W       = 45;
    localparam int VALUE_W       = 5;
    localparam int POS_W         = 5;
    localparam int NUM_W         = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 45;

    localparam logic [COUNT_W-1:0] COUNT_CAP = {COUNT_W{1'b1}};

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ITEMS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RANK = 1'b1;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_CLR,
        CS_MRD,
        CS_MWAIT,
        CS_SCAN,
        CS_PRD,
        CS_PWR,
        CS_TRD
    } t_cnt_state;

    typedef enum logic [3:0] {
        TS_IDLE,
        TS_CLOSE,
        TS_CHECK,
        TS_TOTAL_WAIT,
        TS_PICK,
        TS_PICK_WAIT,
        TS_EMIT,
        TS_NOANS
    } t_top_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cnt_stat;

endpackage

FILE: hdl/klef_in_if.sv
interface klef_in_if import klef_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [POS_W-1:0] smaller_pos;
    logic [POS_W-1:0] larger_pos;

    modport source (output valid, command, smaller_pos, larger_pos, input ready);
    modport sink (input valid, command, smaller_pos, larger_pos, output ready);
endinterface

FILE: hdl/klef_out_if.sv
interface klef_out_if import klef_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               unsolved;
    logic               last;

    modport source (output valid, value, unsolved, last, input ready);
    modport sink (input valid, value, unsolved, last, output ready);
endinterface

FILE: hdl/klef_count.sv
`include "kth_linear_extension_finder_core_defines.svh"

module klef_count import klef_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] i_n,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] i_fixed,
    input  logic [MAX_ITEMS-1:0] i_pred [MAX_ITEMS],
    input  logic [VALUE_W-1:0]   i_chosen [MAX_ITEMS],
    output t_cnt_stat            o_stat,
    output logic [COUNT_W-1:0]   o_total
);
    localparam int AW = MAX_ITEMS;
    localparam int PW = $clog2(MAX_ITEMS);
    localparam int NW = $clog2(MAX_ITEMS + 1);

    t_cnt_state r_state, n_state;

    logic [COUNT_W-1:0] mem [2**AW];
    logic [COUNT_W-1:0] r_rd;
    logic [AW:0]        r_idx;
    logic [AW-1:0]      r_mask;
    logic [AW-1:0]      r_cand;
    logic [AW-1:0]      r_nm;
    logic [PW-1:0]      r_p;
    logic [COUNT_W-1:0] r_c;
    logic [COUNT_W-1:0] r_total;
    logic               r_done;

    logic [AW:0]        w_size, w_fullx;
    logic [AW-1:0]      w_full;
    logic [VALUE_W-1:0] w_k;
    logic [AW-1:0]      w_slot;
    logic [AW-1:0]      w_nm;
    logic               w_ok;
    logic               w_plast;
    logic               w_clr_end;
    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [COUNT_W-1:0] w_wdata;
    logic [COUNT_W:0]   w_sum;

    assign w_size    = (AW+1)'(1) << i_n;
    assign w_fullx   = w_size - (AW+1)'(1);
    assign w_full    = w_fullx[AW-1:0];
    assign w_clr_end = (r_idx == w_fullx);
    assign w_plast   = (NW'(r_p) == i_n - NW'(1));
    assign w_nm      = r_mask | (AW'(1) << r_p);
    assign w_ok      = r_cand[r_p] && ((w_nm & i_pred[r_p]) == i_pred[r_p]);
    assign w_sum     = {1'b0, r_rd} + {1'b0, r_c};

    // The value placed next is one more than the number of positions taken.
    always_comb begin
        w_k = VALUE_W'(1);
        for (int b = 0; b < AW; b++) begin
            w_k = w_k + VALUE_W'(r_mask[b]);
        end
        w_slot = w_full;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (i < int'(i_fixed) && i_chosen[i] == w_k) begin
                w_slot = AW'(1) << i;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_IDLE:  if (i_start) n_state = CS_CLR;
            CS_CLR:   if (w_clr_end) n_state = CS_MRD;
            CS_MRD:   n_state = CS_MWAIT;
            CS_MWAIT: begin
                if (r_mask == w_full) begin
                    n_state = CS_TRD;
                end else if (r_rd == '0) begin
                    n_state = CS_MRD;
                end else begin
                    n_state = CS_SCAN;
                end
            end
            CS_SCAN: begin
                if (w_ok) begin
                    n_state = CS_PRD;
                end else if (w_plast) begin
                    n_state = CS_MRD;
                end
            end
            CS_PRD:   n_state = CS_PWR;
            CS_PWR:   n_state = w_plast ? CS_MRD : CS_SCAN;
            CS_TRD:   n_state = CS_IDLE;
            default:  n_state = CS_IDLE;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_nm;
        w_wdata = w_sum[COUNT_W] ? COUNT_CAP : w_sum[COUNT_W-1:0];
        w_raddr = r_mask;
        case (r_state)
            CS_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = (r_idx == '0) ? COUNT_W'(1) : '0;
            end
            CS_PRD:  w_raddr = r_nm;
            CS_PWR:  w_we = 1'b1;
            CS_TRD:  w_raddr = w_full;
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == CS_TRD);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            CS_IDLE: begin
                r_idx  <= '0;
                r_mask <= '0;
            end
            CS_CLR:  r_idx <= r_idx + (AW+1)'(1);
            CS_MWAIT: begin
                r_c    <= r_rd;
                r_cand <= w_slot & ~r_mask & w_full;
                r_p    <= '0;
                if (r_mask != w_full && r_rd == '0) begin
                    r_mask <= r_mask + AW'(1);
                end
            end
            CS_SCAN: begin
                r_nm <= w_nm;
                if (!w_ok) begin
                    if (w_plast) begin
                        r_mask <= r_mask + AW'(1);
                    end else begin
                        r_p <= r_p + PW'(1);
                    end
                end
            end
            CS_PWR: begin
                if (w_plast) begin
                    r_mask <= r_mask + AW'(1);
                end else begin
                    r_p <= r_p + PW'(1);
                end
            end
            default: r_idx <= r_idx;
        endcase
        if (r_done) begin
            r_total <= r_rd;
        end
    end

    // The total is captured from the read of the full mask in the done cycle.
    assign o_total     = r_done ? r_rd : r_total;
    assign o_stat.busy = (r_state != CS_IDLE);
    assign o_stat.done = r_done;

    `KLEF_ASSERT_SAME(a_start_idle, i_start, r_state == CS_IDLE, "count start while busy")
    `KLEF_ASSERT_NEXT(a_start_clear, i_start, r_state == CS_CLR, "count did not start clearing")
    `KLEF_ASSERT_SAME(a_done_idle, r_done, r_state == CS_IDLE, "count done while busy")
    `KLEF_ASSERT_SAME(a_idle_nowrite, r_state == CS_IDLE, !w_we, "table written while idle")
endmodule

FILE: hdl/kth_linear_extension_finder_core.sv
// Finds the rank-th labelling, in lexicographic order, of positions 1..n with
// the values 1..n that respects every stored "a gets a smaller value than b"
// request. A solve request first closes the constraint graph, then runs one
// counting pass for the total and one for every candidate value tried, at
// most n*n + 1 passes. Each pass clears 2^n table entries, reads every mask,
// scans the positions of each mask whose count is nonzero, updates every
// extension that it feeds and fetches the total, all through the count table
// of 2^MAX_ITEMS words of 45 bits, with one read and one write port, which
// sets the solve time. Results then leave one per cycle while the sink takes
// them; the block takes no new request until the last result has gone.
module kth_linear_extension_finder_core import klef_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    klef_in_if.sink               i_in,
    klef_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int PW = $clog2(MAX_ITEMS);
    localparam int NW = $clog2(MAX_ITEMS + 1);

    t_top_state r_state, n_state;

    logic [NUM_W-1:0]     r_num;
    logic [COUNT_W-1:0]   r_target;
    logic [MAX_ITEMS-1:0] r_matrix [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] r_rows   [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] r_pred   [MAX_ITEMS];
    logic [VALUE_W-1:0]   r_chosen [MAX_ITEMS];
    logic [MAX_ITEMS:0]   r_used;
    logic [COUNT_W-1:0]   r_rem;
    logic [NW-1:0]        r_n;
    logic [PW-1:0]        r_k;
    logic [PW-1:0]        r_i;
    logic [NW-1:0]        r_v;
    logic [PW-1:0]        r_oi;
    logic                 r_bad;

    logic [NW-1:0]        w_n;
    logic [MAX_ITEMS-1:0] w_full;
    logic [MAX_ITEMS:0]   w_fullx;
    logic [POS_W-1:0]     w_a, w_b;
    logic                 w_a_ok, w_b_ok;
    logic                 w_self;
    logic                 w_cyc;
    logic [MAX_ITEMS-1:0] w_tr [MAX_ITEMS];
    logic                 w_klast, w_ilast, w_vlast, w_olast;
    logic                 w_fit;
    logic                 w_start;
    logic [NW-1:0]        w_fixed;
    logic                 w_acc;
    t_cnt_stat            w_stat;
    logic [COUNT_W-1:0]   w_total;

    always_comb begin
        if (r_num == '0) begin
            w_n = NW'(1);
        end else if (r_num > NUM_W'(MAX_ITEMS)) begin
            w_n = NW'(MAX_ITEMS);
        end else begin
            w_n = NW'(r_num);
        end
    end

    assign w_fullx = ((MAX_ITEMS+1)'(1) << w_n) - (MAX_ITEMS+1)'(1);
    assign w_full  = w_fullx[MAX_ITEMS-1:0];
    assign w_a     = i_in.smaller_pos - POS_W'(1);
    assign w_b     = i_in.larger_pos - POS_W'(1);
    assign w_a_ok  = (i_in.smaller_pos != '0) && (i_in.smaller_pos <= POS_W'(MAX_ITEMS));
    assign w_b_ok  = (i_in.larger_pos != '0) && (i_in.larger_pos <= POS_W'(MAX_ITEMS));
    assign w_acc   = i_in.valid && i_in.ready;
    assign w_klast = (NW'(r_k) == r_n - NW'(1));
    assign w_ilast = (NW'(r_i) == r_n - NW'(1));
    assign w_vlast = (r_v == r_n);
    assign w_olast = (NW'(r_oi) == r_n - NW'(1));
    assign w_fit   = (w_total >= r_rem);

    always_comb begin
        w_self = 1'b0;
        w_cyc  = 1'b0;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (i < int'(w_n) && r_matrix[i][i]) begin
                w_self = 1'b1;
            end
            for (int j = 0; j < MAX_ITEMS; j++) begin
                w_tr[j][i] = r_rows[i][j];
            end
        end
        // Two distinct positions that reach each other form a cycle.
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if ((r_rows[i] & w_tr[i] & ~(MAX_ITEMS'(1) << i)) != '0) begin
                w_cyc = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            TS_IDLE:  if (w_acc && i_in.command == CMD_SOLVE) n_state = TS_CLOSE;
            TS_CLOSE: if (w_klast) n_state = TS_CHECK;
            TS_CHECK: n_state = (r_bad || w_cyc) ? TS_NOANS : TS_TOTAL_WAIT;
            TS_TOTAL_WAIT: begin
                if (w_stat.done) n_state = w_fit ? TS_PICK : TS_NOANS;
            end
            TS_PICK: begin
                if (!r_used[r_v]) begin
                    n_state = TS_PICK_WAIT;
                end else if (w_vlast && w_ilast) begin
                    n_state = TS_EMIT;
                end
            end
            TS_PICK_WAIT: begin
                if (w_stat.done) begin
                    if ((w_fit || w_vlast) && w_ilast) begin
                        n_state = TS_EMIT;
                    end else begin
                        n_state = TS_PICK;
                    end
                end
            end
            TS_EMIT:  if (o_out.ready && w_olast) n_state = TS_IDLE;
            TS_NOANS: if (o_out.ready) n_state = TS_IDLE;
            default:  n_state = TS_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready     = 1'b0;
        o_out.valid    = 1'b0;
        o_out.value    = '0;
        o_out.unsolved = 1'b0;
        o_out.last     = 1'b0;
        w_start        = 1'b0;
        w_fixed        = '0;
        case (r_state)
            TS_IDLE:  i_in.ready = 1'b1;
            TS_CHECK: w_start = !(r_bad || w_cyc);
            TS_PICK: begin
                w_start = !r_used[r_v];
                w_fixed = NW'(r_i) + NW'(1);
            end
            TS_PICK_WAIT: w_fixed = NW'(r_i) + NW'(1);
            TS_EMIT: begin
                o_out.valid = 1'b1;
                o_out.value = r_chosen[r_oi];
                o_out.last  = w_olast;
            end
            TS_NOANS: begin
                o_out.valid    = 1'b1;
                o_out.unsolved = 1'b1;
                o_out.last     = 1'b1;
            end
            default: w_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= TS_IDLE;
            r_num    <= NUM_W'(16);
            r_target <= COUNT_W'(1);
            for (int i = 0; i < MAX_ITEMS; i++) begin
                r_matrix[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_ITEMS:   r_num <= i_cfg_data[NUM_W-1:0];
                    CFG_TARGET_RANK: r_target <= i_cfg_data[COUNT_W-1:0];
                    default:         r_num <= r_num;
                endcase
            end
            if (r_state == TS_IDLE && w_acc && i_in.command == CMD_ADD && w_a_ok && w_b_ok) begin
                r_matrix[w_a[PW-1:0]][w_b[PW-1:0]] <= 1'b1;
            end
            if (r_state == TS_CHECK) begin
                for (int i = 0; i < MAX_ITEMS; i++) begin
                    r_matrix[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            TS_IDLE: begin
                r_n     <= w_n;
                r_k     <= '0;
                r_i     <= '0;
                r_v     <= NW'(1);
                r_oi    <= '0;
                r_used  <= '0;
                r_bad   <= w_self;
                r_rem   <= (r_target == '0) ? COUNT_W'(1) : r_target;
                for (int i = 0; i < MAX_ITEMS; i++) begin
                    r_rows[i] <= (i < int'(w_n)) ?
                                 ((r_matrix[i] & w_full) | (MAX_ITEMS'(1) << i)) : '0;
                end
            end
            TS_CLOSE: begin
                for (int i = 0; i < MAX_ITEMS; i++) begin
                    if (r_rows[i][r_k]) r_rows[i] <= r_rows[i] | r_rows[r_k];
                end
                r_k <= r_k + PW'(1);
            end
            TS_CHECK: begin
                for (int j = 0; j < MAX_ITEMS; j++) begin
                    r_pred[j] <= w_tr[j];
                end
            end
            TS_PICK: begin
                if (!r_used[r_v]) begin
                    r_chosen[r_i] <= VALUE_W'(r_v);
                end else if (w_vlast) begin
                    r_i <= r_i + PW'(1);
                    r_v <= NW'(1);
                end else begin
                    r_v <= r_v + NW'(1);
                end
            end
            TS_PICK_WAIT: begin
                if (w_stat.done) begin
                    if (w_fit) begin
                        r_used[r_v] <= 1'b1;
                        r_i <= r_i + PW'(1);
                        r_v <= NW'(1);
                    end else begin
                        r_rem <= r_rem - w_total;
                        if (w_vlast) begin
                            r_i <= r_i + PW'(1);
                            r_v <= NW'(1);
                        end else begin
                            r_v <= r_v + NW'(1);
                        end
                    end
                end
            end
            TS_EMIT: if (o_out.ready) r_oi <= r_oi + PW'(1);
            default: r_k <= r_k;
        endcase
    end

    klef_count #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_count (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_n      (r_n),
        .i_fixed  (w_fixed),
        .i_pred   (r_pred),
        .i_chosen (r_chosen),
        .o_stat   (w_stat),
        .o_total  (w_total)
    );
endmodule
